// ===== hdl/line_position_centroid_macros.svh =====
// ----------------------------------------------------------------------------
// Line position centroid - assertion macros
// Shared concurrent assertion forms for the line position block.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_CENTROID_MACROS_SVH
`define LINE_POSITION_CENTROID_MACROS_SVH

// same-cycle implication
`define LPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_position_centroid: check failed");

// next-cycle implication
`define LPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_position_centroid: check failed");

`endif

// ===== hdl/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg
// Types, widths and weight tables for the line position centroid block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

    localparam int LPC_SENSOR_COUNT = 8;
    localparam int LPC_MAX_SAMPLES  = 16;

    localparam int LPC_WEIGHT_W = 12;
    localparam int LPC_SUM_W    = 18;
    localparam int LPC_MAG_W    = LPC_SUM_W - 1;
    localparam int LPC_HIT_W    = 8;
    localparam int LPC_LHIT_W   = $clog2(LPC_SENSOR_COUNT + 1);
    localparam int LPC_SCNT_W   = $clog2(LPC_MAX_SAMPLES + 1);
    localparam int LPC_STEP_W   = $clog2(LPC_MAG_W);
    localparam int LPC_POS_W    = 12;

    localparam logic signed [LPC_WEIGHT_W-1:0] LPC_COARSE_W [LPC_SENSOR_COUNT] = '{
        -12'sd16, -12'sd8, -12'sd4, 12'sd0, 12'sd0, 12'sd4, 12'sd8, 12'sd16
    };

    localparam logic signed [LPC_WEIGHT_W-1:0] LPC_FINE_W [LPC_SENSOR_COUNT] = '{
        -12'sd2000, -12'sd1333, -12'sd667, -12'sd167,
        12'sd167, 12'sd667, 12'sd1333, 12'sd2000
    };

    typedef struct packed {
        logic                           hit;
        logic signed [LPC_WEIGHT_W-1:0] weight;
    } t_lane_word;

    typedef struct packed {
        logic                        go;
        logic signed [LPC_SUM_W-1:0] sum;
        logic [LPC_HIT_W-1:0]        count;
    } t_div_req;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

endpackage

`default_nettype wire

// ===== hdl/lpc_lane.sv =====
// ----------------------------------------------------------------------------
// lpc_lane
// One sensor lane: picks the weight of its sensor when that sensor hits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_lane
    import lpc_pkg::*;
(
    input  wire logic                           i_hit,
    input  wire logic                           i_mode,
    input  wire logic signed [LPC_WEIGHT_W-1:0] i_coarse,
    input  wire logic signed [LPC_WEIGHT_W-1:0] i_fine,
    output t_lane_word                          o_word
);

    always_comb begin
        o_word.hit = i_hit;
        if (!i_hit) begin
            o_word.weight = '0;
        end else if (i_mode) begin
            o_word.weight = i_fine;
        end else begin
            o_word.weight = i_coarse;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lpc_merge.sv =====
// ----------------------------------------------------------------------------
// lpc_merge
// Combines the lane words and keeps the running sum, hit and sample counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_merge
    import lpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic       i_last,
    input  wire t_lane_word i_lanes [LPC_SENSOR_COUNT],
    output t_div_req        o_req
);

    logic signed [LPC_SUM_W-1:0] r_sum, n_sum;
    logic [LPC_HIT_W-1:0]        r_hits, n_hits;
    logic [LPC_SCNT_W-1:0]       r_samples, n_samples;

    logic signed [LPC_SUM_W-1:0] w_lane_sum;
    logic [LPC_LHIT_W-1:0]       w_lane_hits;
    logic signed [LPC_SUM_W-1:0] w_sum_tot;
    logic [LPC_HIT_W-1:0]        w_hits_tot;
    logic                        w_close;

    always_comb begin
        w_lane_sum  = '0;
        w_lane_hits = '0;
        for (int k = 0; k < LPC_SENSOR_COUNT; k++) begin
            w_lane_sum  = w_lane_sum + LPC_SUM_W'(i_lanes[k].weight);
            w_lane_hits = w_lane_hits + LPC_LHIT_W'(i_lanes[k].hit);
        end
    end

    assign w_sum_tot  = r_sum + w_lane_sum;
    assign w_hits_tot = r_hits + LPC_HIT_W'(w_lane_hits);
    assign w_close    = i_last || (r_samples == LPC_SCNT_W'(LPC_MAX_SAMPLES - 1));

    always_comb begin
        n_sum     = r_sum;
        n_hits    = r_hits;
        n_samples = r_samples;
        if (i_take) begin
            if (w_close) begin
                n_sum     = '0;
                n_hits    = '0;
                n_samples = '0;
            end else begin
                n_sum     = w_sum_tot;
                n_hits    = w_hits_tot;
                n_samples = r_samples + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_hits    <= '0;
            r_samples <= '0;
        end else begin
            r_sum     <= n_sum;
            r_hits    <= n_hits;
            r_samples <= n_samples;
        end
    end

    assign o_req.go    = i_take && w_close;
    assign o_req.sum   = w_sum_tot;
    assign o_req.count = w_hits_tot;

endmodule

`default_nettype wire

// ===== hdl/lpc_div.sv =====
// ----------------------------------------------------------------------------
// lpc_div
// Serial signed divider: sum / count, truncated toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_div
    import lpc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_div_req                    i_req,
    output logic                             o_busy,
    output logic                             o_valid,
    output logic signed [LPC_POS_W-1:0]      o_position,
    output logic                             o_no_line
);

    t_div_state r_state, n_state;
    logic [LPC_STEP_W-1:0] r_step;

    logic [LPC_MAG_W-1:0]  r_num;
    logic [LPC_HIT_W-1:0]  r_rem;
    logic [LPC_HIT_W-1:0]  r_den;
    logic                  r_neg;
    logic                  r_nohit;

    logic [LPC_SUM_W-1:0]  w_abs;
    logic [LPC_HIT_W:0]    w_rem_sh;
    logic                  w_fits;
    logic [LPC_HIT_W:0]    w_rem_sub;
    logic [LPC_POS_W-1:0]  w_qmag;

    assign w_abs     = i_req.sum[LPC_SUM_W-1] ? (-i_req.sum) : i_req.sum;
    assign w_rem_sh  = {r_rem, r_num[LPC_MAG_W-1]};
    assign w_fits    = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_qmag    = r_num[LPC_POS_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: begin
                if (i_req.go) begin
                    n_state = (i_req.count == '0) ? DIV_DONE : DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_step == LPC_STEP_W'(LPC_MAG_W - 1)) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                n_state = DIV_IDLE;
            end
            default: begin
                n_state = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == DIV_RUN) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_req.go) begin
            r_num   <= w_abs[LPC_MAG_W-1:0];
            r_rem   <= '0;
            r_den   <= i_req.count;
            r_neg   <= i_req.sum[LPC_SUM_W-1];
            r_nohit <= (i_req.count == '0);
        end else if (r_state == DIV_RUN) begin
            r_num <= {r_num[LPC_MAG_W-2:0], w_fits};
            r_rem <= w_fits ? w_rem_sub[LPC_HIT_W-1:0] : w_rem_sh[LPC_HIT_W-1:0];
        end
    end

    always_comb begin
        o_busy     = 1'b1;
        o_valid    = 1'b0;
        o_no_line  = 1'b0;
        o_position = '0;
        case (r_state)
            DIV_IDLE: begin
                o_busy = 1'b0;
            end
            DIV_RUN: begin
                o_busy = 1'b1;
            end
            DIV_DONE: begin
                o_valid   = 1'b1;
                o_no_line = r_nohit;
                if (!r_nohit) begin
                    o_position = r_neg ? $signed(-w_qmag) : $signed(w_qmag);
                end
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/line_position_centroid.sv =====
// ----------------------------------------------------------------------------
// line_position_centroid
// Weighted-centroid line position from eight binary sensors.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   input    | start / busy           | i_sensor_bits, i_last_sample
//   result   | o_result_valid strobe  | o_position, o_no_line
//   config   | i_cfg_we               | i_cfg_wdata (weight_mode)
//
// A snapshot word that does not close a reading is accumulated; busy stays low.
// A closing word is added to the sums and handed to the serial divider
// (one quotient bit a cycle), which then presents the result. A reading with
// no hits skips the divider. Synchronous active-low reset clears the
// accumulators and sets fine weights. The result is a one-cycle strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_position_centroid_macros.svh"

module line_position_centroid
    import lpc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [LPC_SENSOR_COUNT-1:0] i_sensor_bits,
    input  wire logic                        i_last_sample,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_wdata,
    output logic                             o_result_valid,
    output logic signed [LPC_POS_W-1:0]      o_position,
    output logic                             o_no_line
);

    logic       r_weight_mode;
    logic       w_take;
    logic       w_busy;
    t_lane_word w_lanes [LPC_SENSOR_COUNT];
    t_div_req   w_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_weight_mode <= i_cfg_wdata;
        end
    end

    assign w_take = start && !w_busy;
    assign busy   = w_busy;

    for (genvar g = 0; g < LPC_SENSOR_COUNT; g++) begin : g_lane
        lpc_lane u_lane (
            .i_hit    (i_sensor_bits[g]),
            .i_mode   (r_weight_mode),
            .i_coarse (LPC_COARSE_W[g]),
            .i_fine   (LPC_FINE_W[g]),
            .o_word   (w_lanes[g])
        );
    end

    lpc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_last  (i_last_sample),
        .i_lanes (w_lanes),
        .o_req   (w_req)
    );

    lpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_busy     (w_busy),
        .o_valid    (o_result_valid),
        .o_position (o_position),
        .o_no_line  (o_no_line)
    );

    `LPC_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_result_valid, busy)
    `LPC_ASSERT_IMP(a_noline_zero, i_clk, i_rst_n, o_result_valid && o_no_line, o_position == '0)
    `LPC_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, o_result_valid, (o_position >= -12'sd2000) && (o_position <= 12'sd2000))
    `LPC_ASSERT_NXT(a_valid_free, i_clk, i_rst_n, o_result_valid, !busy && !o_result_valid)

endmodule

`default_nettype wire
